// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RGB to HSV converter RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define RGBHSV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define RGBHSV_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/rgbhsv_pkg.sv =====
// Shared types and constants of the RGB to HSV converter.
// No dependencies; used by the interfaces, the front stage, the divider cells and the top.
package rgbhsv_pkg;

	localparam int CH_W      = 8;           // color channel width
	localparam int HUE_W     = 16;          // hue fraction width
	localparam int HDIV_W    = 11;          // 6 * spread fits in 11 bits
	localparam int SDND_W    = 2 * CH_W;    // 255 * spread
	localparam int NUM_CELLS = HUE_W;       // one quotient bit per cell

	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [HUE_W-1:0]  hue_t;
	typedef logic [HDIV_W-1:0] hdiv_t;
	typedef logic [SDND_W-1:0] sdnd_t;

	// Word handed from cell to cell along the divider chain.
	typedef struct packed {
		hdiv_t hue_rem;
		hdiv_t hue_div;
		hue_t  hue_quo;
		chan_t sat_rem;
		chan_t sat_div;
		sdnd_t sat_dnd;
		chan_t sat_quo;
		chan_t value;
	} cell_word_t;

endpackage

// ===== rtl/core/rgbhsv_pix_if.sv =====
// Input channel of the converter: one RGB pixel word per handshake.
// Depends on rgbhsv_pkg.
interface rgbhsv_pix_if import rgbhsv_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/rgbhsv_hsv_if.sv =====
// Output channel of the converter: one HSV word per handshake.
// Depends on rgbhsv_pkg.
interface rgbhsv_hsv_if import rgbhsv_pkg::*; ();
	logic  valid;
	logic  ready;
	hue_t  hue;
	chan_t saturation;
	chan_t brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

// ===== rtl/core/rgb_to_hsv_converter.sv =====
// Top level of the RGB to HSV converter: front stage, divider cell chain, output register.
// Depends on rgbhsv_pkg, rgbhsv_pix_if, rgbhsv_hsv_if, rgbhsv_prep, rgbhsv_cell.
//
// Usage:
//   pix carries one RGB word (red, green, blue, 8 bits each) per valid/ready handshake.
//   hsv returns one word per pixel, in order: hue as a 16-bit fraction of a full turn,
//   saturation = floor(255 * spread / max), brightness = max channel.
//   Path: the front stage register loads at the accepting edge; the word then passes
//   through 16 divider cells and 1 output register before it reaches hsv.
//   Throughput: one pixel per clock unless hsv.ready stalls the chain; the 16 cells each
//   do one quotient bit of each division, so a new pixel enters as older ones move down.
//   Stall: when hsv.ready is low the output register holds its word; each stage keeps
//   advancing while the one after it has room, so bubbles are squeezed out and pix.ready
//   drops only once every stage holds a word.
//   Reset: arst_n clears all valid flags asynchronously; no word is emitted until a
//   pixel is accepted. The block keeps no state between pixels.
`include "assert_macros.svh"

module rgb_to_hsv_converter import rgbhsv_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	rgbhsv_pix_if.sink  pix,
	rgbhsv_hsv_if.source hsv
);

	cell_word_t stage_word [NUM_CELLS+1];
	logic       stage_vld  [NUM_CELLS+1];
	logic       stage_rdy  [NUM_CELLS+1];

	logic  out_valid_q;
	hue_t  hue_q;
	chan_t sat_q;
	chan_t bright_q;
	logic  out_rdy;

	// Front stage: max/min/spread and the division operands.
	rgbhsv_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.red      (pix.red),
		.green    (pix.green),
		.blue     (pix.blue),
		.up_valid (pix.valid),
		.up_ready (pix.ready),
		.dn_word  (stage_word[0]),
		.dn_ready (stage_rdy[0]),
		.dn_valid (stage_vld[0])
	);

	// Divider chain: each cell shifts one quotient bit into both results.
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		rgbhsv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_word  (stage_word[i]),
			.up_valid (stage_vld[i]),
			.up_ready (stage_rdy[i]),
			.dn_word  (stage_word[i+1]),
			.dn_valid (stage_vld[i+1]),
			.dn_ready (stage_rdy[i+1])
		);
	end

	// Output register: take a new word when empty or when the receiver drains it.
	assign out_rdy              = !out_valid_q || hsv.ready;
	assign stage_rdy[NUM_CELLS] = out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_rdy) begin
			out_valid_q <= stage_vld[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && stage_vld[NUM_CELLS]) begin
			hue_q    <= stage_word[NUM_CELLS].hue_quo;
			sat_q    <= stage_word[NUM_CELLS].sat_quo;
			bright_q <= stage_word[NUM_CELLS].value;
		end
	end

	assign hsv.valid      = out_valid_q;
	assign hsv.hue        = hue_q;
	assign hsv.saturation = sat_q;
	assign hsv.brightness = bright_q;

	// Zero saturation means a grey pixel, so hue must be zero too.
	`RGBHSV_ASSERT(a_top_grey_hue, clk, arst_n,
		(hsv.valid && (hsv.saturation == '0)) |-> (hsv.hue == '0), "grey pixel with hue")
	// An empty output register lets the whole chain advance.
	`RGBHSV_ASSERT(a_top_ready, clk, arst_n,
		!hsv.valid |-> pix.ready, "input stalled with empty output")
	`RGBHSV_ASSERT_NEXT(a_top_last_hold, clk, arst_n, stage_vld[NUM_CELLS] && !out_rdy,
		stage_vld[NUM_CELLS], "last cell dropped a word")

endmodule

// ===== rtl/core/rgbhsv_prep.sv =====
// Front stage: max, min, spread and the two division operands of one pixel.
// Depends on rgbhsv_pkg and assert_macros.svh; feeds the first divider cell.
`include "assert_macros.svh"

module rgbhsv_prep import rgbhsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  chan_t      red,
	input  chan_t      green,
	input  chan_t      blue,
	input  logic       up_valid,
	output logic       up_ready,
	output cell_word_t dn_word,
	input  logic       dn_ready,
	output logic       dn_valid
);

	logic       valid_s1;
	cell_word_t word_s1;
	cell_word_t word_d;
	logic       red_max;
	logic       green_max;
	chan_t      vmax;
	chan_t      vmin;
	chan_t      spread;
	hdiv_t      spread_w;
	hdiv_t      six_d;
	hdiv_t      num;

	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		vmax = red_max ? red : (green_max ? green : blue);
		vmin = red;
		if (green < vmin) begin
			vmin = green;
		end
		if (blue < vmin) begin
			vmin = blue;
		end
		spread   = vmax - vmin;
		spread_w = {{(HDIV_W-CH_W){1'b0}}, spread};
		six_d    = (spread_w << 2) + (spread_w << 1);
		// All numerators land in [0, 6d), so modulo arithmetic is exact.
		if (red_max) begin
			if (green >= blue) begin
				num = {{(HDIV_W-CH_W){1'b0}}, green - blue};
			end else begin
				num = six_d - {{(HDIV_W-CH_W){1'b0}}, blue - green};
			end
		end else if (green_max) begin
			num = (spread_w << 1) + {{(HDIV_W-CH_W){1'b0}}, blue}
				- {{(HDIV_W-CH_W){1'b0}}, red};
		end else begin
			num = (spread_w << 2) + {{(HDIV_W-CH_W){1'b0}}, red}
				- {{(HDIV_W-CH_W){1'b0}}, green};
		end

		word_d = '0;
		// Grey: zero over one gives a zero quotient.
		word_d.hue_rem = (spread == '0) ? '0 : num;
		word_d.hue_div = (spread == '0) ? hdiv_t'(1) : six_d;
		word_d.sat_div = (vmax == '0) ? chan_t'(1) : vmax;
		word_d.sat_dnd = {spread, {CH_W{1'b0}}} - {{CH_W{1'b0}}, spread};
		word_d.value   = vmax;
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s1 <= word_d;
		end
	end

	assign dn_word  = word_s1;
	assign dn_valid = valid_s1;

	`RGBHSV_ASSERT(a_prep_hue_frac, clk, arst_n,
		valid_s1 |-> (word_s1.hue_rem < word_s1.hue_div), "hue numerator not below divisor")
	`RGBHSV_ASSERT(a_prep_sat_fit, clk, arst_n,
		valid_s1 |-> (word_s1.sat_dnd[SDND_W-1:CH_W] < word_s1.sat_div),
		"saturation quotient would overflow")
	`RGBHSV_ASSERT_NEXT(a_prep_hold, clk, arst_n, valid_s1 && !dn_ready,
		valid_s1 && $stable(word_s1), "front stage lost a stalled word")

endmodule

// ===== rtl/core/rgbhsv_cell.sv =====
// One divider cell: a restoring step for hue and one for saturation.
// Depends on rgbhsv_pkg and assert_macros.svh; chained by the top level.
`include "assert_macros.svh"

module rgbhsv_cell import rgbhsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_word_t up_word,
	input  logic       up_valid,
	output logic       up_ready,
	output cell_word_t dn_word,
	output logic       dn_valid,
	input  logic       dn_ready
);

	logic                valid_q;
	cell_word_t          word_q;
	cell_word_t          word_d;
	logic [HDIV_W:0]     hue_trial;
	logic [HDIV_W:0]     hue_diff;
	logic                hue_bit;
	logic [CH_W:0]       sat_trial;
	logic [CH_W:0]       sat_diff;
	logic                sat_bit;

	always_comb begin
		word_d    = up_word;
		hue_trial = {up_word.hue_rem, 1'b0};
		hue_diff  = hue_trial - {1'b0, up_word.hue_div};
		hue_bit   = (hue_trial >= {1'b0, up_word.hue_div});
		sat_trial = {up_word.sat_rem, up_word.sat_dnd[SDND_W-1]};
		sat_diff  = sat_trial - {1'b0, up_word.sat_div};
		sat_bit   = (sat_trial >= {1'b0, up_word.sat_div});

		word_d.hue_rem = hue_bit ? hue_diff[HDIV_W-1:0] : hue_trial[HDIV_W-1:0];
		word_d.hue_quo = {up_word.hue_quo[HUE_W-2:0], hue_bit};
		word_d.sat_rem = sat_bit ? sat_diff[CH_W-1:0] : sat_trial[CH_W-1:0];
		word_d.sat_dnd = {up_word.sat_dnd[SDND_W-2:0], 1'b0};
		word_d.sat_quo = {up_word.sat_quo[CH_W-2:0], sat_bit};
	end

	// Advance when empty or when the neighbor takes the held word.
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_q <= word_d;
		end
	end

	assign dn_word  = word_q;
	assign dn_valid = valid_q;

	`RGBHSV_ASSERT(a_cell_hue_rem, clk, arst_n,
		valid_q |-> (word_q.hue_rem < word_q.hue_div), "hue remainder out of range")
	`RGBHSV_ASSERT(a_cell_sat_rem, clk, arst_n,
		valid_q |-> (word_q.sat_rem < word_q.sat_div), "saturation remainder out of range")
	`RGBHSV_ASSERT_NEXT(a_cell_hold, clk, arst_n, valid_q && !dn_ready,
		valid_q && $stable(word_q), "cell lost a stalled word")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the rgb_to_hsv_converter pixel pipeline.
// Depends on rgbhsv_pkg, rgbhsv_pix_if, rgbhsv_hsv_if and the converter RTL.
`timescale 1ns / 1ps

module tb;
	import rgbhsv_pkg::*;

	localparam int LATENCY      = 17;    // accepting edge to hsv.valid
	localparam int SETTLE_WAIT  = 3 * LATENCY;
	localparam int LIMIT_CYCLES = 2000;  // cycles without any handshake
	localparam int HUE_SCALE    = 65536;
	localparam int SAT_SCALE    = 255;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_pixel_t;

	typedef struct packed {
		hue_t  hue;
		chan_t saturation;
		chan_t brightness;
	} hsv_word_t;

	logic clk;
	logic arst_n;

	rgbhsv_pix_if pix ();
	rgbhsv_hsv_if hsv ();

	rgb_to_hsv_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix.sink),
		.hsv    (hsv.source)
	);

	// Words still owed by the converter, oldest first.
	hsv_word_t expected_hsv[$];

	int idle_pct;      // chance in a hundred that the pixel source idles a cycle
	int stall_pct;     // chance in a hundred that the HSV sink stalls a cycle
	int pixels_sent;
	int words_checked;
	int mismatches;
	int quiet_cycles;

	// Free-running 50 MHz clock: low half, then high half.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Hexcone conversion of one pixel. The hue numerator is base * d + x - y,
	// kept non-negative by taking base 6 when red leads and green < blue.
	function automatic hsv_word_t hsv_of_pixel(rgb_pixel_t p);
		int unsigned r, g, b, v, mn, d, num;
		hsv_word_t w;
		r = p.red;
		g = p.green;
		b = p.blue;
		v = r;
		mn = r;
		if (g > v) v = g;
		if (b > v) v = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = v - mn;
		// Ties for the largest channel go to red, then green.
		if (d == 0)
			num = 0;
		else if (r == v)
			num = (g >= b) ? (g - b) : (6 * d - (b - g));
		else if (g == v)
			num = 2 * d + b - r;
		else
			num = 4 * d + r - g;
		// Grey pixels carry hue 0; black carries saturation 0.
		w.hue        = (d == 0) ? '0 : hue_t'((HUE_SCALE * num) / (6 * d));
		w.saturation = (v == 0) ? '0 : chan_t'((SAT_SCALE * d) / v);
		w.brightness = chan_t'(v);
		return w;
	endfunction

	// Draw a pixel, biased toward greys, ties, tiny and near-full channels.
	function automatic rgb_pixel_t random_pixel();
		rgb_pixel_t p;
		chan_t      top;
		p.red   = chan_t'($urandom);
		p.green = chan_t'($urandom);
		p.blue  = chan_t'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				p.green = p.red;
				p.blue  = p.red;
			end
			1: begin
				// two channels share the maximum, the third sits below
				top = chan_t'($urandom);
				case ($urandom_range(0, 2))
					0: p = '{top, top, chan_t'($urandom_range(0, top))};
					1: p = '{top, chan_t'($urandom_range(0, top)), top};
					default: p = '{chan_t'($urandom_range(0, top)), top, top};
				endcase
			end
			2: p = '{chan_t'($urandom_range(0, 3)), chan_t'($urandom_range(0, 3)),
				chan_t'($urandom_range(0, 3))};
			3: p = '{chan_t'($urandom_range(250, 255)), chan_t'($urandom_range(250, 255)),
				chan_t'($urandom_range(0, 255))};
			default: ;
		endcase
		return p;
	endfunction

	// Offer one pixel word: idle at random first, then hold valid until accepted.
	// Leave valid high on return so back-to-back words need no extra edge.
	task automatic send_pixel(input rgb_pixel_t p);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.red   <= p.red;
		pix.green <= p.green;
		pix.blue  <= p.blue;
		do
			@(posedge clk);
		while (!pix.ready);
		expected_hsv.push_back(hsv_of_pixel(p));
		pixels_sent++;
	endtask

	// Drop valid and hold off until every owed word has come back.
	task automatic wait_for_drain();
		@(negedge clk);
		pix.valid <= 1'b0;
		while (expected_hsv.size() != 0)
			@(posedge clk);
	endtask

	// Corners: black, white, greys, pure primaries, every tie order, and each
	// hue sector including red leading with green below blue (base 6).
	task automatic test_directed_corners();
		idle_pct  = 0;
		stall_pct = 0;
		send_pixel('{8'd0, 8'd0, 8'd0});
		send_pixel('{8'd255, 8'd255, 8'd255});
		send_pixel('{8'd128, 8'd128, 8'd128});
		send_pixel('{8'd1, 8'd1, 8'd1});
		send_pixel('{8'd255, 8'd0, 8'd0});
		send_pixel('{8'd0, 8'd255, 8'd0});
		send_pixel('{8'd0, 8'd0, 8'd255});
		send_pixel('{8'd255, 8'd255, 8'd0});
		send_pixel('{8'd255, 8'd0, 8'd255});
		send_pixel('{8'd0, 8'd255, 8'd255});
		send_pixel('{8'd255, 8'd0, 8'd1});
		send_pixel('{8'd255, 8'd1, 8'd0});
		send_pixel('{8'd10, 8'd255, 8'd0});
		send_pixel('{8'd0, 8'd255, 8'd10});
		send_pixel('{8'd10, 8'd0, 8'd255});
		send_pixel('{8'd0, 8'd10, 8'd255});
		send_pixel('{8'd1, 8'd0, 8'd0});
		send_pixel('{8'd0, 8'd1, 8'd0});
		send_pixel('{8'd0, 8'd0, 8'd1});
		send_pixel('{8'd255, 8'd254, 8'd0});
		send_pixel('{8'd170, 8'd85, 8'd255});
		send_pixel('{8'd127, 8'd128, 8'd129});
	endtask

	// Stream random pixels under one idling and stalling pattern.
	task automatic test_random_stream(input int count, input int idle, input int stall);
		idle_pct  = idle;
		stall_pct = stall;
		repeat (count)
			send_pixel(random_pixel());
	endtask

	// Let the pipeline run dry mid-stream, then refill it from empty.
	task automatic test_pause_and_resume();
		idle_pct  = 35;
		stall_pct = 35;
		repeat (12)
			send_pixel(random_pixel());
		wait_for_drain();
		repeat (12)
			send_pixel(random_pixel());
	endtask

	// Sink side: pick ready at the falling edge so it is stable at the rising edge.
	always @(negedge clk)
		hsv.ready <= ($urandom_range(0, 99) >= stall_pct);

	// Compare each delivered word against the oldest prediction.
	always @(posedge clk) begin
		hsv_word_t want;
		if (arst_n && hsv.valid && hsv.ready) begin
			if (expected_hsv.size() == 0) begin
				$error("hsv word with nothing owed: hue=%0d saturation=%0d brightness=%0d",
					hsv.hue, hsv.saturation, hsv.brightness);
				mismatches++;
			end else begin
				want = expected_hsv.pop_front();
				words_checked++;
				if (hsv.hue !== want.hue) begin
					$error("hue: expected %0d, got %0d", want.hue, hsv.hue);
					mismatches++;
				end
				if (hsv.saturation !== want.saturation) begin
					$error("saturation: expected %0d, got %0d", want.saturation,
						hsv.saturation);
					mismatches++;
				end
				if (hsv.brightness !== want.brightness) begin
					$error("brightness: expected %0d, got %0d", want.brightness,
						hsv.brightness);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (hsv.valid && hsv.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= LIMIT_CYCLES) begin
			$display("Timeout: no handshake in %0d cycles, %0d words still owed",
				LIMIT_CYCLES, expected_hsv.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		// Drive every input to a known value before the first edge.
		arst_n        = 1'b0;
		pix.valid     = 1'b0;
		pix.red       = '0;
		pix.green     = '0;
		pix.blue      = '0;
		hsv.ready     = 1'b0;
		idle_pct      = 0;
		stall_pct     = 0;
		pixels_sent   = 0;
		words_checked = 0;
		mismatches    = 0;
		quiet_cycles  = 0;

		// Hold reset, then release it away from the rising edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_corners();
		test_random_stream(95, 0, 0);
		test_random_stream(95, 59, 0);
		test_random_stream(95, 0, 59);
		test_pause_and_resume();
		test_random_stream(75, 35, 35);

		// Drop valid, collect the tail, then watch for stray words.
		wait_for_drain();
		repeat (SETTLE_WAIT) @(posedge clk);

		$display("Converted %0d pixels and checked %0d HSV words across corner, burst,",
			pixels_sent, words_checked);
		$display("source-idle, sink-stall, mixed and drain-and-refill traffic.");
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d field mismatches", mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rgbhsv_pkg.sv
rtl/core/rgbhsv_pix_if.sv
rtl/core/rgbhsv_hsv_if.sv
rtl/core/rgbhsv_prep.sv
rtl/core/rgbhsv_cell.sv
rtl/core/rgb_to_hsv_converter.sv
dv/tb.sv
